// ===== rtl/mexp_pkg.sv =====
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared widths, reset constants, command codes and sequencer state type for
// the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

    // Operand and result width
    localparam int unsigned VAL_W      = 31;
    // Width of the exponent port
    localparam int unsigned EXP_PORT_W = 63;
    // Step counter of the serial multiplier, one step per multiplier bit
    localparam int unsigned CNT_W      = $clog2(VAL_W);

    typedef logic [VAL_W-1:0] val_t;

    // Modulus after reset
    localparam val_t MODULUS_RESET = 31'd1000000007;

    // Command codes
    localparam logic CMD_POW = 1'b0;
    localparam logic CMD_INV = 1'b1;

    // Exponentiation sequencer
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EVAL,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

endpackage

// ===== rtl/modular_exponentiation.sv =====
// The base is first reduced on the one bit-serial multiplier; then each square or
// multiply costs a decision state plus a run of that multiplier, with h squares and s
// multiplies, where h is the position of the highest set exponent bit and s the number
// of set bits. A modulus below two skips the multiplier and gives zero.
// One transaction at a time; the next is taken in the cycle after the result is loaded,
// later while a held result stalls the load. Reset: async, active low; modulus 1000000007.
// ----------------------------------------------------------------------------
// modular_exponentiation
// Right-to-left square-and-multiply of base to exponent modulo a configured
// modulus; the inverse command uses modulus minus two as exponent.
// ----------------------------------------------------------------------------
module modular_exponentiation #(
    parameter int unsigned EXPONENT_BITS = 63
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Configuration
    input  logic                              modulus_we,
    input  logic [mexp_pkg::VAL_W-1:0]        modulus_wdata,
    // Input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              cmd,
    input  logic [mexp_pkg::VAL_W-1:0]        base,
    input  logic [mexp_pkg::EXP_PORT_W-1:0]   exponent,
    // Output channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mexp_pkg::VAL_W-1:0]        result
);

    localparam int unsigned EXP_W = (EXPONENT_BITS > mexp_pkg::VAL_W) ?
                                    EXPONENT_BITS : mexp_pkg::VAL_W;

    mexp_pkg::state_t   state_reg;
    mexp_pkg::state_t   state_next;
    mexp_pkg::val_t     modulus_reg;
    logic [EXP_W-1:0]   exp_reg;
    logic [EXP_W-1:0]   exp_next;
    mexp_pkg::val_t     acc_reg;
    mexp_pkg::val_t     acc_next;
    mexp_pkg::val_t     sq_reg;
    mexp_pkg::val_t     sq_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    mexp_pkg::val_t     result_reg;
    mexp_pkg::val_t     result_next;

    logic               in_accept;
    logic               mod_ok;
    mexp_pkg::val_t     inv_exp;
    logic               mm_start;
    mexp_pkg::val_t     mm_x;
    mexp_pkg::val_t     mm_y;
    logic               mm_busy;
    logic               mm_done;
    mexp_pkg::val_t     mm_product;

    assign in_stall  = (state_reg != mexp_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign mod_ok    = (modulus_reg > mexp_pkg::val_t'(1));
    assign inv_exp   = modulus_reg - mexp_pkg::val_t'(2);

    // Shared modular multiplier
    mexp_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mm_start),
        .x       (mm_x),
        .y       (mm_y),
        .m       (modulus_reg),
        .busy    (mm_busy),
        .done    (mm_done),
        .product (mm_product)
    );

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        mm_start       = 1'b0;
        mm_x           = sq_reg;
        mm_y           = sq_reg;
        out_valid_next = out_valid_reg && out_stall;
        result_next    = result_reg;

        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (mod_ok)
                    begin
                        if (cmd == mexp_pkg::CMD_INV)
                        begin
                            exp_next = EXP_W'(inv_exp);
                        end
                        else
                        begin
                            exp_next = EXP_W'(exponent[EXPONENT_BITS-1:0]);
                        end
                        // base mod m as 1 * base
                        acc_next   = mexp_pkg::val_t'(1);
                        mm_start   = 1'b1;
                        mm_x       = mexp_pkg::val_t'(1);
                        mm_y       = base;
                        state_next = mexp_pkg::ST_REDUCE;
                    end
                    else
                    begin
                        // degenerate modulus gives zero
                        acc_next   = '0;
                        state_next = mexp_pkg::ST_FINISH;
                    end
                end
            end

            mexp_pkg::ST_REDUCE:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_product;
                    state_next = mexp_pkg::ST_EVAL;
                end
            end

            mexp_pkg::ST_EVAL:
            begin
                if (exp_reg == '0)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mm_start   = 1'b1;
                    mm_x       = sq_reg;
                    mm_y       = acc_reg;
                    state_next = mexp_pkg::ST_MUL;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = mexp_pkg::ST_SQR;
                end
            end

            mexp_pkg::ST_MUL:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_product;
                    exp_next   = {exp_reg[EXP_W-1:1], 1'b0};
                    state_next = mexp_pkg::ST_EVAL;
                end
            end

            mexp_pkg::ST_SQR:
            begin
                if (mm_done)
                begin
                    sq_next    = mm_product;
                    exp_next   = {1'b0, exp_reg[EXP_W-1:1]};
                    state_next = mexp_pkg::ST_EVAL;
                end
            end

            mexp_pkg::ST_FINISH:
            begin
                // load once the output register is free or being emptied
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = acc_reg;
                    state_next     = mexp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= mexp_pkg::MODULUS_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (modulus_we)
            begin
                modulus_reg <= modulus_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // An accepted transaction blocks the input until it is finished
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("input not stalled after accepting a transaction");

    // Multiplier only runs while the sequencer waits on it
    a_mul_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (mm_busy || mm_done) |-> (state_reg == mexp_pkg::ST_REDUCE ||
                                  state_reg == mexp_pkg::ST_MUL ||
                                  state_reg == mexp_pkg::ST_SQR))
        else $error("multiplier active outside a multiply state");

    // Leaving FINISH always presents a result
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mexp_pkg::ST_FINISH && !(out_valid_reg && out_stall))
        |=> (out_valid_reg && state_reg == mexp_pkg::ST_IDLE))
        else $error("finished transaction not loaded into output register");

endmodule

// ===== rtl/mexp_mulmod.sv =====
// ----------------------------------------------------------------------------
// mexp_mulmod
// Bit-serial interleaved modular multiplier: x * y mod m, x below m, one bit
// of y per cycle, MSB first, while busy; done pulses for one cycle with the final product.
// ----------------------------------------------------------------------------
module mexp_mulmod (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  mexp_pkg::val_t x,
    input  mexp_pkg::val_t y,
    input  mexp_pkg::val_t m,
    output logic          busy,
    output logic          done,
    output mexp_pkg::val_t product
);

    localparam int unsigned TW = mexp_pkg::VAL_W + 2;

    logic                        busy_reg;
    logic                        done_reg;
    logic [mexp_pkg::CNT_W-1:0]  cnt_reg;
    mexp_pkg::val_t              x_reg;
    mexp_pkg::val_t              y_reg;
    mexp_pkg::val_t              p_reg;
    mexp_pkg::val_t              p_next;

    logic [TW-1:0]  t;
    logic [TW-1:0]  m1;
    logic [TW-1:0]  m2;
    logic [TW:0]    d1;
    logic [TW:0]    d2;
    logic           last_step;

    // One step: p = 2p + bit*x, then pull back below m (sum stays below 3m)
    always_comb
    begin
        t  = {1'b0, p_reg, 1'b0} + {2'b00, (y_reg[mexp_pkg::VAL_W-1] ? x_reg : '0)};
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        d1 = {1'b0, t} - {1'b0, m1};
        d2 = {1'b0, t} - {1'b0, m2};
        if (!d2[TW])
        begin
            p_next = d2[mexp_pkg::VAL_W-1:0];
        end
        else if (!d1[TW])
        begin
            p_next = d1[mexp_pkg::VAL_W-1:0];
        end
        else
        begin
            p_next = t[mexp_pkg::VAL_W-1:0];
        end
    end

    assign last_step = (cnt_reg == mexp_pkg::CNT_W'(mexp_pkg::VAL_W - 1));

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            p_reg <= '0;
        end
        else if (busy_reg)
        begin
            y_reg <= {y_reg[mexp_pkg::VAL_W-2:0], 1'b0};
            p_reg <= p_next;
        end
    end

    assign busy    = busy_reg;
    assign done    = done_reg;
    assign product = p_reg;

endmodule

// ===== verif/mexp_checker.sv =====
// ----------------------------------------------------------------------------
// mexp_checker
// Follows the modulus register and both handshake channels of the modular
// exponentiation block. Predicts each result from the accepted operands and
// compares it with the results that come out, in order.
// ----------------------------------------------------------------------------
module mexp_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            modulus_we,
    input  mexp_pkg::val_t                  modulus_wdata,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic                            cmd,
    input  mexp_pkg::val_t                  base,
    input  logic [mexp_pkg::EXP_PORT_W-1:0] exponent,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  mexp_pkg::val_t                  result,
    output int                              outstanding,
    output int                              mismatch_count
);

    timeunit 1ns;
    timeprecision 1ps;

    mexp_pkg::val_t modulus_shadow;
    mexp_pkg::val_t pending_results[$];

    initial mismatch_count = 0;
    initial outstanding    = 0;

    // Right-to-left square-and-multiply; products stay below 2^62
    function automatic mexp_pkg::val_t mod_power(logic op, mexp_pkg::val_t b,
                                                 logic [mexp_pkg::EXP_PORT_W-1:0] e,
                                                 mexp_pkg::val_t m);
        logic [63:0]                     acc;
        logic [63:0]                     sq;
        logic [63:0]                     m64;
        logic [mexp_pkg::EXP_PORT_W-1:0] pw;
        if (m < mexp_pkg::val_t'(2))
            return '0;
        m64 = {33'd0, m};
        pw  = (op == mexp_pkg::CMD_INV) ?
              mexp_pkg::EXP_PORT_W'(m - mexp_pkg::val_t'(2)) : e;
        acc = 64'd1;
        sq  = {33'd0, b};
        for (int i = 0; i < mexp_pkg::EXP_PORT_W; i++)
        begin
            if (pw[i])
                acc = (acc * sq) % m64;
            sq = (sq * sq) % m64;
        end
        return mexp_pkg::val_t'(acc);
    endfunction

    task automatic report_mismatch(string what, mexp_pkg::val_t got, mexp_pkg::val_t want);
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Track modulus, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin : track
        mexp_pkg::val_t want;
        if (!rst_n)
        begin
            modulus_shadow <= mexp_pkg::MODULUS_RESET;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // pop first so a stray result never matches a same-cycle transaction
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result with no transaction pending", result, '0);
                else
                begin
                    want = pending_results.pop_front();
                    if (result !== want)
                        report_mismatch("result", result, want);
                end
            end
            if (in_valid && !in_stall)
                pending_results.insert(pending_results.size(),
                                       mod_power(cmd, base, exponent, modulus_shadow));
            if (modulus_we)
                modulus_shadow <= modulus_wdata;
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench top for modular_exponentiation. Drives directed corner operands
// under several moduli, then random phases with varying modulus and idling on
// both channels; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles to let pass after the last result before a verdict or a write
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_ITEMS    = 45;
    localparam mexp_pkg::val_t MOD_MAX = 31'h7FFF_FFFF;
    localparam logic [mexp_pkg::EXP_PORT_W-1:0] EXP_MAX = '1;

    logic                            clk;
    logic                            rst_n         = 1'b0;
    logic                            modulus_we    = 1'b0;
    mexp_pkg::val_t                  modulus_wdata = '0;
    logic                            in_valid      = 1'b0;
    logic                            in_stall;
    logic                            cmd           = mexp_pkg::CMD_POW;
    mexp_pkg::val_t                  base          = '0;
    logic [mexp_pkg::EXP_PORT_W-1:0] exponent      = '0;
    logic                            out_valid;
    logic                            out_stall     = 1'b0;
    mexp_pkg::val_t                  result;

    int outstanding;
    int mismatch_count;
    int send_idle_pct = 26;
    int recv_idle_pct = 49;

    modular_exponentiation #(
        .EXPONENT_BITS (63)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .modulus_we    (modulus_we),
        .modulus_wdata (modulus_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .base          (base),
        .exponent      (exponent),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result        (result)
    );

    mexp_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .modulus_we     (modulus_we),
        .modulus_wdata  (modulus_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .base           (base),
        .exponent       (exponent),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result         (result),
        .outstanding    (outstanding),
        .mismatch_count (mismatch_count)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stall
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_idle_pct);

    // Present one transaction, with a random gap before it
    task automatic send_operand(logic op, mexp_pkg::val_t b,
                                logic [mexp_pkg::EXP_PORT_W-1:0] e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= op;
        base     <= b;
        exponent <= e;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait until every predicted result has come out, then let the block settle
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_modulus(mexp_pkg::val_t m);
        wait_drained();
        modulus_wdata <= m;
        modulus_we    <= 1'b1;
        @(posedge clk);
        modulus_we    <= 1'b0;
        @(posedge clk);
    endtask

    function automatic mexp_pkg::val_t pick_modulus();
        case ($urandom_range(4))
            0:
            begin
                case ($urandom_range(5))
                    0: return 31'd1000000007;
                    1: return 31'd998244353;
                    2: return MOD_MAX;
                    3: return 31'd65537;
                    4: return 31'd3;
                    default: return 31'd13;
                endcase
            end
            1: return mexp_pkg::val_t'($urandom_range(64, 2));
            2: return mexp_pkg::val_t'(32'h4000_0000 | $urandom_range(32'h3FFF_FFFF));
            default: return mexp_pkg::val_t'($urandom_range(32'h7FFF_FFFF, 2));
        endcase
    endfunction

    // Mostly short exponents; a few full-width ones reach the slow path
    task automatic send_random();
        logic                            op;
        mexp_pkg::val_t                  b;
        logic [mexp_pkg::EXP_PORT_W-1:0] e;
        op = ($urandom_range(99) < 25) ? mexp_pkg::CMD_INV : mexp_pkg::CMD_POW;
        b  = mexp_pkg::val_t'($urandom);
        if ($urandom_range(9) == 0)
            b = mexp_pkg::val_t'($urandom_range(3));
        e = mexp_pkg::EXP_PORT_W'({$urandom, $urandom});
        if ($urandom_range(9) != 0)
            e &= (mexp_pkg::EXP_PORT_W'(1) << $urandom_range(12)) -
                 mexp_pkg::EXP_PORT_W'(1);
        send_operand(op, b, e);
    endtask

    // Stimulus and verdict
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners under the reset modulus
        send_operand(mexp_pkg::CMD_POW, '0, '0);
        send_operand(mexp_pkg::CMD_POW, '0, 63'd1);
        send_operand(mexp_pkg::CMD_POW, MOD_MAX, EXP_MAX);
        send_operand(mexp_pkg::CMD_POW, MOD_MAX, '0);
        send_operand(mexp_pkg::CMD_POW, mexp_pkg::MODULUS_RESET, 63'd3);
        send_operand(mexp_pkg::CMD_POW, 31'd2, 63'h4000_0000_0000_0000);
        send_operand(mexp_pkg::CMD_POW, 31'h2AAA_AAAA, 63'h5555_5555_5555_5555);
        send_operand(mexp_pkg::CMD_POW, 31'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
        send_operand(mexp_pkg::CMD_INV, '0, EXP_MAX);
        send_operand(mexp_pkg::CMD_INV, 31'd2, '0);
        send_operand(mexp_pkg::CMD_INV, MOD_MAX, '0);

        // smallest meaningful modulus: inverse of zero gives one
        set_modulus(31'd2);
        send_operand(mexp_pkg::CMD_INV, '0, '0);
        send_operand(mexp_pkg::CMD_INV, 31'd1, EXP_MAX);
        send_operand(mexp_pkg::CMD_POW, 31'd3, 63'd5);
        send_operand(mexp_pkg::CMD_POW, '0, '0);

        // largest modulus, base equal to it
        set_modulus(MOD_MAX);
        send_operand(mexp_pkg::CMD_INV, MOD_MAX, '0);
        send_operand(mexp_pkg::CMD_INV, 31'd12345, '0);
        send_operand(mexp_pkg::CMD_POW, MOD_MAX - 31'd1, EXP_MAX);

        // degenerate moduli give zero
        set_modulus(31'd1);
        send_operand(mexp_pkg::CMD_POW, 31'd5, 63'd3);
        send_operand(mexp_pkg::CMD_INV, '0, '0);
        set_modulus('0);
        send_operand(mexp_pkg::CMD_POW, 31'd5, '0);
        send_operand(mexp_pkg::CMD_INV, 31'd7, '0);

        // random phases: idle pattern swaps, then no idling at all
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p < 3)
            begin
                send_idle_pct = 26;
                recv_idle_pct = 49;
            end
            else if (p < 6)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 26;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_modulus(pick_modulus());
            repeat (PHASE_ITEMS) send_random();
        end

        wait_drained();
        if (mismatch_count == 0)
            $display("modular_exponentiation verification clean");
        else
            $display("modular_exponentiation verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("modular_exponentiation verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/mexp_pkg.sv
rtl/mexp_mulmod.sv
rtl/modular_exponentiation.sv
verif/mexp_checker.sv
verif/tb.sv
